// File: rtl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg: shared constants and types for the pedal position conditioner
// Widths, limits, fault codes, register indexes and curve modes.
// ----------------------------------------------------------------------------
package ppc_pkg;
  localparam int unsigned STUCK_LIMIT_DEF   = 50;
  localparam int unsigned EXTREME_LIMIT_DEF = 20;
  localparam int unsigned ADC_BITS          = 12;

  localparam int unsigned PCT_W     = 15;
  localparam int unsigned FULL_PCT  = 25600;
  localparam int unsigned SLEW_PCT  = 5120;
  localparam int unsigned DB_MAX    = 5120;
  localparam int unsigned EXT_MARGIN = 10;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    FAULT_OK      = 2'd0,
    FAULT_RANGE   = 2'd1,
    FAULT_STUCK   = 2'd2,
    FAULT_EXTREME = 2'd3
  } fault_t;

  typedef enum logic [1:0] {
    REG_LOW_CAL  = 2'd0,
    REG_HIGH_CAL = 2'd1,
    REG_CURVE    = 2'd2,
    REG_DEADBAND = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CURVE_LINEAR = 2'd0,
    CURVE_SMOOTH = 2'd1,
    CURVE_SQRT   = 2'd2,
    CURVE_LIN3   = 2'd3
  } curve_t;
endpackage

// File: rtl/pedal_position_conditioner_unit.sv
// ----------------------------------------------------------------------------
// pedal_position_conditioner_unit: pedal sensor conditioning
// Range, stuck and extreme checks, EMA filter, percent map, curve, slew limit.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* carries one converter sample per transfer (tdata[11:0]).
//   m_axis_* returns one result per sample. The user writes registers through
//   cfg_we/cfg_idx/cfg_data only while the block is idle; it does not enforce this.
//   An item runs through a small sequencer around one shared add/subtract
//   unit: a restoring divider for the percent map (load plus 32 steps), a
//   restoring divider for smoothstep scaling (load plus 15 steps) and a
//   bit-pair square root (load plus 16 steps).
//   The result goes to the output register in S_SLEW, or in S_CHECK for
//   range, stuck and extreme faults, which skip filter, map and curve;
//   m_axis_tvalid then rises in S_OUT. With the receiver ready the
//   sequencer returns to idle once the result is taken and then accepts
//   the next sample; samples are not overlapped.
//   s_axis_tready is high only while the sequencer is idle; a new sample is
//   taken once the previous result has left the output register.
//   Reset clears filter, counters, last output and restores register
//   defaults. A stalled receiver holds the result and the block waits.
// ----------------------------------------------------------------------------
module pedal_position_conditioner_unit
  import ppc_pkg::*;
#(
  parameter int unsigned STUCK_LIMIT   = STUCK_LIMIT_DEF,
  parameter int unsigned EXTREME_LIMIT = EXTREME_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // adc_sample[11:0], zero fill to bytes
  input  logic [((ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pedal_percent[14:0], position_valid[15], filtered_sample[27:16],
  // fault_code[29:28], zeros above
  output logic [31:0]           m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int unsigned AW = ADC_BITS;
  localparam int unsigned EW = AW + 8;
  localparam logic [AW-1:0] FULL_ADC = {AW{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_EMA, S_MAP, S_DIV, S_DB, S_SM1, S_SM2, S_SDIV,
    S_SQRT, S_SLEW, S_OUT
  } state_t;

  state_t state;
  logic [AW-1:0] low_cal, high_cal;
  logic [1:0] curve_mode;
  logic [12:0] deadband;

  logic [EW-1:0] ema_value;
  logic ema_started;
  logic [AW-1:0] previous_sample;
  logic previous_sample_seen;
  logic [5:0] stuck_count;
  logic [4:0] extreme_count;
  logic [PCT_W-1:0] last_output_percent;

  logic [AW-1:0] raw;
  logic [AW:0] span;
  // shared datapath registers
  logic [63:0] num;      // dividend / radicand shift register
  logic [43:0] rem;      // partial remainder
  logic [43:0] dvs;      // divisor
  logic [31:0] quo;
  logic [5:0]  cnt;
  logic [15:0] m_val;
  logic [31:0] prod;

  // shared adder: one subtract used by divider and root
  logic [44:0] sub_a, sub_b, sub_d;
  assign sub_d = sub_a - sub_b;

  logic [43:0] rem_sh;
  always_comb begin
    rem_sh = {rem[42:0], num[63]};
    sub_a  = {1'b0, rem_sh};
    sub_b  = {1'b0, dvs};
    if (state == S_SQRT) begin
      sub_a = {1'b0, rem[41:0], num[63:62]};
      sub_b = {11'd0, quo, 2'b01};
    end
  end

  // window check; margin is floor(span / 10) by reciprocal multiply
  logic [AW+1:0] margin;
  logic [AW+1:0] lo_w, hi_w;
  logic out_rng;
  always_comb begin
    span   = (high_cal > low_cal) ? ({1'b0, high_cal} - {1'b0, low_cal}) : (AW+1)'(1);
    margin = (AW+2)'((32'(span) * 32'd52429) >> 19);
    lo_w   = {2'b0, low_cal};
    hi_w   = (AW+2)'(low_cal) + (AW+2)'(span) + margin;
    out_rng = ((AW+2)'(raw) + margin < lo_w) || ((AW+2)'(raw) > hi_w);
  end

  logic [12:0] db_eff;
  assign db_eff = (deadband > 13'(DB_MAX)) ? 13'(DB_MAX) : deadband;

  logic [AW-1:0] filt;
  assign filt = ema_value[EW-1:8];

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_LOW_CAL:  low_cal  <= AW'(cfg_data);
        REG_HIGH_CAL: high_cal <= AW'(cfg_data);
        REG_CURVE:    curve_mode <= cfg_data[1:0];
        REG_DEADBAND: deadband <= cfg_data;
        default: ;
      endcase
    end
    if (rst) begin
      low_cal <= AW'(200); high_cal <= AW'(3800);
      curve_mode <= 2'd0; deadband <= 13'd768;
      state <= S_IDLE; m_axis_tvalid <= 1'b0;
      ema_value <= '0; ema_started <= 1'b0;
      previous_sample <= '0; previous_sample_seen <= 1'b0;
      stuck_count <= '0; extreme_count <= '0; last_output_percent <= '0;
    end else begin
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          raw <= s_axis_tdata[AW-1:0];
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (out_rng) begin
            m_axis_tdata <= {2'b0, FAULT_RANGE, filt, 1'b0, last_output_percent};
            state <= S_OUT;
          end else begin
            previous_sample <= raw;
            previous_sample_seen <= 1'b1;
            if (previous_sample_seen && raw == previous_sample &&
                ((stuck_count == 6'd63 ? 6'd63 : stuck_count + 6'd1) >= 6'(STUCK_LIMIT))) begin
              if (stuck_count != 6'd63) stuck_count <= stuck_count + 6'd1;
              m_axis_tdata <= {2'b0, FAULT_STUCK, 28'd0};
              state <= S_OUT;
            end else begin
              if (previous_sample_seen && raw == previous_sample) begin
                if (stuck_count != 6'd63) stuck_count <= stuck_count + 6'd1;
              end else stuck_count <= '0;
              if (raw <= AW'(EXT_MARGIN) || raw >= FULL_ADC - AW'(EXT_MARGIN)) begin
                if (extreme_count != 5'd31) extreme_count <= extreme_count + 5'd1;
                if ((extreme_count == 5'd31 ? 5'd31 : extreme_count + 5'd1) >=
                    5'(EXTREME_LIMIT)) begin
                  m_axis_tdata <= {2'b0, FAULT_EXTREME, 28'd0};
                  state <= S_OUT;
                end else state <= S_EMA;
              end else begin
                extreme_count <= '0;
                state <= S_EMA;
              end
            end
          end
        end
        S_EMA: begin
          ema_started <= 1'b1;
          if (!ema_started) ema_value <= {raw, 8'd0};
          else ema_value <= EW'(((EW+8)'(raw) * 38 * 256 + (EW+8)'(ema_value) * 218
                                 + 128) >> 8);
          state <= S_MAP;
        end
        S_MAP: begin
          // clamp filter to window, scale by 25600, then divide by span
          if (filt <= low_cal) prod <= '0;
          else if ((AW+1)'(filt) >= (AW+1)'(low_cal) + span)
            prod <= 32'(span) * 32'(FULL_PCT);
          else prod <= 32'(filt - low_cal) * 32'(FULL_PCT);
          state <= S_DIV;
          cnt <= 6'd0;
        end
        S_DIV: begin
          if (cnt == 6'd0) begin
            num <= {prod, 32'd0}; rem <= '0; dvs <= 44'(span); quo <= '0;
            cnt <= 6'd1;
          end else begin
            num <= {num[62:0], 1'b0};
            if (!sub_d[44]) begin rem <= sub_d[43:0]; quo <= {quo[30:0], 1'b1}; end
            else begin rem <= rem_sh; quo <= {quo[30:0], 1'b0}; end
            cnt <= cnt + 6'd1;
            if (cnt == 6'd32) state <= S_DB;
          end
        end
        S_DB: begin
          m_val <= (quo[15:0] < 16'(db_eff)) ? 16'd0 : quo[15:0];
          case (curve_t'(curve_mode))
            CURVE_SMOOTH: state <= S_SM1;
            CURVE_SQRT: begin
              state <= S_SQRT; cnt <= 6'd0;
            end
            default: begin
              prod <= (quo[15:0] < 16'(db_eff)) ? 32'd0 : 32'(quo[15:0]);
              state <= S_SLEW;
            end
          endcase
        end
        S_SM1: begin prod <= 32'(m_val) * 32'(m_val); state <= S_SM2; end
        S_SM2: begin
          num <= 64'(prod) * 64'(17'(3 * FULL_PCT) - {m_val, 1'b0});
          rem <= '0; dvs <= 44'(FULL_PCT * FULL_PCT); quo <= '0; cnt <= 6'd0;
          state <= S_SDIV;
        end
        S_SDIV: begin
          if (cnt == 6'd0) begin
            // quotient fits 15 bits, so the upper product bits are the first remainder
            rem <= 44'(num[43:15]); num <= {num[14:0], 49'd0};
            cnt <= 6'd1;
          end else begin
            num <= {num[62:0], 1'b0};
            if (!sub_d[44]) begin rem <= sub_d[43:0]; quo <= {quo[30:0], 1'b1}; end
            else begin rem <= rem_sh; quo <= {quo[30:0], 1'b0}; end
            cnt <= cnt + 6'd1;
            if (cnt == 6'd15) state <= S_SLEW;
          end
        end
        S_SQRT: begin
          if (cnt == 6'd0) begin
            num <= {32'(m_val) * 32'(FULL_PCT), 32'd0}; rem <= '0; quo <= '0;
            cnt <= 6'd1;
          end else begin
            num <= {num[61:0], 2'b00};
            if (!sub_d[44]) begin rem <= sub_d[43:0]; quo <= {quo[30:0], 1'b1}; end
            else begin rem <= {rem[41:0], num[63:62]}; quo <= {quo[30:0], 1'b0}; end
            cnt <= cnt + 6'd1;
            if (cnt == 6'd16) state <= S_SLEW;
          end
        end
        S_SLEW: begin : slew
          logic [31:0] p;
          logic [PCT_W-1:0] pc;
          p = (curve_t'(curve_mode) inside {CURVE_SQRT, CURVE_SMOOTH}) ? quo : prod;
          if (p > 32'(FULL_PCT)) p = 32'(FULL_PCT);
          pc = PCT_W'(p);
          if (pc > last_output_percent && pc - last_output_percent > PCT_W'(SLEW_PCT))
            pc = last_output_percent + PCT_W'(SLEW_PCT);
          else if (last_output_percent > pc &&
                   last_output_percent - pc > PCT_W'(SLEW_PCT))
            pc = last_output_percent - PCT_W'(SLEW_PCT);
          last_output_percent <= pc;
          m_axis_tdata <= {2'b0, FAULT_OK, filt, 1'b1, pc};
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid) m_axis_tvalid <= 1'b1;
          else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("input open while result held");
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> state == S_OUT) else $error("result outside output state");
  a_pct_rng: assert property (@(posedge clk) disable iff (rst)
    last_output_percent <= PCT_W'(FULL_PCT)) else $error("percent out of range");
endmodule
